// ===== design/dawl_pkg.sv =====
// Shared types and constants for the device access whitelist check.
package dawl_pkg;

  localparam int ENTRIES_DEF = 1024;
  localparam int SLOT_W      = 10;
  localparam int ID_W        = 32;
  localparam int KIND_W      = 16;
  localparam int FLAG_W      = 16;

  localparam logic [ID_W-1:0] WILD_ID = '1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  typedef struct packed {
    logic              live;
    logic [ID_W-1:0]   major;
    logic [ID_W-1:0]   minor;
    logic [KIND_W-1:0] kind;
    logic [FLAG_W-1:0] mask;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [ID_W-1:0]   major;
    logic [ID_W-1:0]   minor;
    logic [KIND_W-1:0] kind;
    logic [FLAG_W-1:0] flags;
  } req_t;

  typedef struct packed {
    logic clr;
    logic vld;
  } match_ctl_t;

endpackage

// ===== design/dawl_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module dawl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/dawl_match.sv =====
// Entry match logic with the hit accumulator for one table scan.
module dawl_match (
  input  logic                clk,
  input  logic                rst_n,
  input  dawl_pkg::match_ctl_t ctl,
  input  dawl_pkg::entry_t    entry,
  input  dawl_pkg::req_t      req,
  output logic                hit
);
  import dawl_pkg::*;

  logic match;
  logic hit_r;
  logic hit_nxt;

  always_comb begin
    match = entry.live
          && (entry.kind == req.kind)
          && ((entry.major == req.major) || (entry.major == WILD_ID))
          && ((entry.minor == req.minor) || (entry.minor == WILD_ID))
          && ((entry.mask & req.flags) == req.flags);
    hit_nxt = hit_r;
    if (ctl.clr) begin
      hit_nxt = 1'b0;
    end else if (ctl.vld && match) begin
      hit_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  assign hit = hit_r;

endmodule

// ===== design/device_access_whitelist_check.sv =====
// Top level of the device access whitelist check with its scan sequencer.
//
//   Channel | Direction | Handshake        | Payload
//   in_     | input     | in_valid/in_stall | op, slot, slot_valid, major, minor,
//           |           |                  | device_kind, flags
//   out_    | output    | out_valid/out_stall | allowed, was_check
//
// A write request gives its deny result in the next cycle; a check request reads every
// table slot once through the single read port, followed by the drain and finish states.
// After reset a clearing pass writes every slot invalid, and no request is
// accepted until it ends.
// A stalled result holds in the output register; a request is taken only
// when the sequencer is idle and the output register is free.
module device_access_whitelist_check #(
  parameter int ENTRIES = dawl_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic [dawl_pkg::SLOT_W-1:0] in_slot,
  input  logic                        in_slot_valid,
  input  logic [dawl_pkg::ID_W-1:0]   in_major,
  input  logic [dawl_pkg::ID_W-1:0]   in_minor,
  input  logic [dawl_pkg::KIND_W-1:0] in_device_kind,
  input  logic [dawl_pkg::FLAG_W-1:0] in_flags,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_allowed,
  output logic                        out_was_check
);
  import dawl_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_t;

  state_t     state_r;
  logic [AW-1:0] idx_r;
  logic       rd_vld_r;
  req_t       req_r;
  logic       out_valid_r;
  logic       out_allowed_r;
  logic       out_was_check_r;

  logic       out_free;
  logic       out_load;
  logic       in_acc;
  logic       slot_ok;
  logic       ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t     ram_wdata;
  entry_t     ram_rdata;
  logic       ram_re;
  match_ctl_t mctl;
  logic       hit;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign slot_ok  = (32'(in_slot) < ENTRIES);
  assign out_load = (in_acc && (in_op == OP_WRITE)) || ((state_r == S_FIN) && out_free);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = '0;
    if (state_r == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (in_acc && (in_op == OP_WRITE) && slot_ok) begin
      ram_we          = 1'b1;
      ram_waddr       = AW'(in_slot);
      ram_wdata.live  = in_slot_valid;
      ram_wdata.major = in_major;
      ram_wdata.minor = in_minor;
      ram_wdata.kind  = in_device_kind;
      ram_wdata.mask  = in_flags;
    end
  end

  assign ram_re   = (state_r == S_SCAN);
  assign mctl.clr = in_acc && (in_op == OP_CHECK);
  assign mctl.vld = rd_vld_r;

  dawl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (idx_r),
    .rd_data (ram_rdata)
  );

  dawl_match u_match (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mctl),
    .entry (ram_rdata),
    .req   (req_r),
    .hit   (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      idx_r           <= '0;
      rd_vld_r        <= 1'b0;
      out_valid_r     <= 1'b0;
      out_allowed_r   <= 1'b0;
      out_was_check_r <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == S_SCAN);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (idx_r == LAST_IDX) begin
            idx_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            if (in_op == OP_CHECK) begin
              req_r.major <= in_major;
              req_r.minor <= in_minor;
              req_r.kind  <= in_device_kind;
              req_r.flags <= in_flags;
              idx_r       <= '0;
              state_r     <= S_SCAN;
            end else begin
              out_allowed_r   <= 1'b0;
              out_was_check_r <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (idx_r == LAST_IDX) begin
            idx_r   <= '0;
            state_r <= S_DRAIN;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DRAIN: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_allowed_r   <= hit;
            out_was_check_r <= 1'b1;
            state_r         <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_allowed   = out_allowed_r;
  assign out_was_check = out_was_check_r;

endmodule

// ===== design/dawl_checker.sv =====
// Port-level assertions for the device access whitelist check and their bind.
module dawl_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic in_op,
  input logic out_valid,
  input logic out_stall,
  input logic out_allowed,
  input logic out_was_check
);
  import dawl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_allowed) && $stable(out_was_check))
    else $error("Stalled result changed or dropped.");

  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == OP_WRITE)
      |=> out_valid && !out_was_check && !out_allowed)
    else $error("Write request did not give a deny result in the next cycle.");

  a_allow_is_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_allowed |-> out_was_check)
    else $error("Allowed result that does not answer a check request.");

  a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == OP_CHECK) |=> in_stall)
    else $error("Request accepted while a table scan is running.");

endmodule

bind device_access_whitelist_check dawl_checker u_dawl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_op         (in_op),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_allowed   (out_allowed),
  .out_was_check (out_was_check)
);
